>>> rtl/msmf_pkg.sv
// Shared types and constants for the MIDI stream message framer.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package msmf_pkg;

    localparam logic [7:0] RT_MIN     = 8'hF8;
    localparam logic [7:0] SOX        = 8'hF0;
    localparam logic [7:0] EOX        = 8'hF7;
    localparam logic [7:0] STATUS_MIN = 8'h80;
    localparam logic [7:0] PROG_CHG   = 8'hC0;
    localparam logic [7:0] CHAN_PRES  = 8'hD0;
    localparam logic [7:0] MTC_QF     = 8'hF1;
    localparam logic [7:0] SONG_POS   = 8'hF2;
    localparam logic [7:0] SONG_SEL   = 8'hF3;
    localparam logic [7:0] KIND_MASK  = 8'hF0;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    // One command from the parser to the message engine.
    typedef struct packed {
        logic       rt;        // real-time byte, emit alone
        logic       clear;     // restart the message buffer first
        logic       prefix;    // store pre_byte ahead of data
        logic       emit;      // message complete after this store
        logic [7:0] pre_byte;
        logic [7:0] data;
    } msmf_cmd_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SECOND,
        BK_READ,
        BK_LOAD
    } msmf_back_state_t;

    function automatic logic [1:0] voice_len(input logic [7:0] st);
        logic [7:0] kind;
        kind = st & KIND_MASK;
        return (kind == PROG_CHG || kind == CHAN_PRES) ? 2'd2 : 2'd3;
    endfunction

    function automatic logic [1:0] system_len(input logic [7:0] st);
        logic [1:0] len;
        len = 2'd1;
        if (st == MTC_QF || st == SONG_SEL) begin
            len = 2'd2;
        end else if (st == SONG_POS) begin
            len = 2'd3;
        end
        return len;
    endfunction

endpackage

>>> rtl/msmf_front.sv
// Parser front end: accepts raw bytes, tracks running status and message length,
// and issues store/emit commands. Depends on msmf_pkg.
`timescale 1ns / 1ps

module msmf_front #(
    parameter int MAX_MSG_BYTES = 64
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [7:0]           s_in_byte,
    input  logic                 q_full,
    output logic                 q_push,
    output msmf_pkg::msmf_cmd_t  q_cmd
);
    import msmf_pkg::*;

    localparam int CW = $clog2(MAX_MSG_BYTES + 1);

    logic [CW-1:0] cnt_reg, cnt_next;
    logic [1:0]    exp_reg, exp_next;
    logic [7:0]    rs_reg, rs_next;
    logic          sysex_reg, sysex_next;
    logic          take;
    logic [1:0]    len;
    logic [CW-1:0] cnt_inc;

    assign s_ready = !q_full;
    assign take    = s_valid && s_ready;
    assign cnt_inc = cnt_reg + CW'(1);

    always_comb begin
        q_push     = 1'b0;
        q_cmd      = '0;
        q_cmd.data = s_in_byte;
        cnt_next   = cnt_reg;
        exp_next   = exp_reg;
        rs_next    = rs_reg;
        sysex_next = sysex_reg;
        len        = 2'd0;
        if (take) begin
            if (s_in_byte >= RT_MIN) begin
                q_push   = 1'b1;
                q_cmd.rt = 1'b1;
            end else if (s_in_byte == EOX) begin
                // drop a stray end of exclusive
                if (sysex_reg) begin
                    q_push     = 1'b1;
                    q_cmd.emit = 1'b1;
                    sysex_next = 1'b0;
                    cnt_next   = '0;
                end
            end else if (s_in_byte >= STATUS_MIN) begin
                q_push      = 1'b1;
                q_cmd.clear = 1'b1;
                sysex_next  = 1'b0;
                if (s_in_byte == SOX) begin
                    rs_next    = 8'h00;
                    sysex_next = 1'b1;
                    cnt_next   = CW'(1);
                end else begin
                    if (s_in_byte >= SOX) begin
                        rs_next = 8'h00;
                        len     = system_len(s_in_byte);
                    end else begin
                        rs_next = s_in_byte;
                        len     = voice_len(s_in_byte);
                    end
                    exp_next = len;
                    if (len == 2'd1) begin
                        q_cmd.emit = 1'b1;
                        cnt_next   = '0;
                    end else begin
                        cnt_next   = CW'(1);
                    end
                end
            end else if (sysex_reg) begin
                q_push = 1'b1;
                // flush a full chunk, keep the dump open
                if (cnt_inc == CW'(MAX_MSG_BYTES)) begin
                    q_cmd.emit = 1'b1;
                    cnt_next   = '0;
                end else begin
                    cnt_next   = cnt_inc;
                end
            end else if (cnt_reg == '0) begin
                // running status: put the stored status back in front
                if (rs_reg != 8'h00) begin
                    q_push         = 1'b1;
                    q_cmd.prefix   = 1'b1;
                    q_cmd.pre_byte = rs_reg;
                    len            = voice_len(rs_reg);
                    exp_next       = len;
                    if (len == 2'd2) begin
                        q_cmd.emit = 1'b1;
                        cnt_next   = '0;
                    end else begin
                        cnt_next   = CW'(2);
                    end
                end
            end else begin
                q_push = 1'b1;
                if (cnt_inc >= CW'(exp_reg)) begin
                    q_cmd.emit = 1'b1;
                    cnt_next   = '0;
                end else begin
                    cnt_next   = cnt_inc;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg   <= '0;
            exp_reg   <= 2'd0;
            rs_reg    <= 8'h00;
            sysex_reg <= 1'b0;
        end else begin
            cnt_reg   <= cnt_next;
            exp_reg   <= exp_next;
            rs_reg    <= rs_next;
            sysex_reg <= sysex_next;
        end
    end

endmodule

>>> rtl/msmf_cmd_fifo.sv
// Short command queue between the parser and the message engine.
// Depends on msmf_pkg for the command type and depth.
`timescale 1ns / 1ps

module msmf_cmd_fifo (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  msmf_pkg::msmf_cmd_t  push_cmd,
    output logic                 full,
    input  logic                 pop,
    output logic                 not_empty,
    output msmf_pkg::msmf_cmd_t  head_cmd
);
    import msmf_pkg::*;

    msmf_cmd_t           slot_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]   count_reg, count_next;
    logic                do_push, do_pop;

    assign full      = (count_reg == (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_cmd  = slot_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> rtl/msmf_back.sv
// Message engine: holds the message buffer, stores bytes per command and drains
// finished messages into the output register. Depends on msmf_pkg.
`timescale 1ns / 1ps

module msmf_back #(
    parameter int MAX_MSG_BYTES = 64
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cmd_valid,
    input  msmf_pkg::msmf_cmd_t  cmd,
    output logic                 cmd_pop,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [7:0]           m_out_byte,
    output logic                 m_end_of_message
);
    import msmf_pkg::*;

    localparam int CW = $clog2(MAX_MSG_BYTES + 1);
    localparam int AW = $clog2(MAX_MSG_BYTES);

    logic [7:0]       mem [MAX_MSG_BYTES];
    logic [7:0]       rdata_reg;

    msmf_back_state_t state_reg, state_next;
    msmf_cmd_t        cmd_reg, cmd_next;
    logic [CW-1:0]    wptr_reg, wptr_next;
    logic [AW-1:0]    rptr_reg, rptr_next;
    logic             oval_reg, oval_next;
    logic [7:0]       obyte_reg, obyte_next;
    logic             oeom_reg, oeom_next;

    logic             out_free;
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [7:0]       mem_wdata;
    logic             mem_re;
    logic [CW-1:0]    base;
    logic             last;

    assign out_free = !oval_reg || m_ready;
    assign base     = cmd.clear ? '0 : wptr_reg;
    assign last     = (CW'(rptr_reg) + CW'(1)) == wptr_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE: begin
                if (cmd_valid && !cmd.rt) begin
                    if (cmd.prefix) begin
                        state_next = BK_SECOND;
                    end else if (cmd.emit) begin
                        state_next = BK_READ;
                    end
                end
            end
            BK_SECOND: begin
                state_next = cmd_reg.emit ? BK_READ : BK_IDLE;
            end
            BK_READ: begin
                if (out_free) begin
                    state_next = BK_LOAD;
                end
            end
            BK_LOAD: begin
                state_next = last ? BK_IDLE : BK_READ;
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd_pop    = 1'b0;
        cmd_next   = cmd_reg;
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        mem_we     = 1'b0;
        mem_waddr  = base[AW-1:0];
        mem_wdata  = cmd.data;
        mem_re     = 1'b0;
        oval_next  = oval_reg;
        obyte_next = obyte_reg;
        oeom_next  = oeom_reg;
        if (m_ready) begin
            oval_next = 1'b0;
        end
        case (state_reg)
            BK_IDLE: begin
                if (cmd_valid) begin
                    if (cmd.rt) begin
                        // real-time byte bypasses the buffer
                        if (out_free) begin
                            cmd_pop    = 1'b1;
                            oval_next  = 1'b1;
                            obyte_next = cmd.data;
                            oeom_next  = 1'b1;
                        end
                    end else begin
                        cmd_pop   = 1'b1;
                        cmd_next  = cmd;
                        mem_we    = 1'b1;
                        mem_wdata = cmd.prefix ? cmd.pre_byte : cmd.data;
                        wptr_next = base + CW'(1);
                        rptr_next = '0;
                    end
                end
            end
            BK_SECOND: begin
                mem_we    = 1'b1;
                mem_waddr = wptr_reg[AW-1:0];
                mem_wdata = cmd_reg.data;
                wptr_next = wptr_reg + CW'(1);
                rptr_next = '0;
            end
            BK_READ: begin
                mem_re = out_free;
            end
            BK_LOAD: begin
                oval_next  = 1'b1;
                obyte_next = rdata_reg;
                oeom_next  = last;
                if (last) begin
                    wptr_next = '0;
                end else begin
                    rptr_next = rptr_reg + 1'b1;
                end
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rdata_reg <= mem[rptr_reg];
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg   <= cmd_next;
        obyte_reg <= obyte_next;
        oeom_reg  <= oeom_next;
        rptr_reg  <= rptr_next;
        if (!aresetn) begin
            state_reg <= BK_IDLE;
            wptr_reg  <= '0;
            oval_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            wptr_reg  <= wptr_next;
            oval_reg  <= oval_next;
        end
    end

    assign m_valid          = oval_reg;
    assign m_out_byte       = obyte_reg;
    assign m_end_of_message = oeom_reg;

endmodule

>>> rtl/midi_stream_message_framer.sv
// Top level of the MIDI stream message framer: parser, command queue and
// message engine. Depends on msmf_pkg, msmf_front, msmf_cmd_fifo, msmf_back.
//
//   channel | ports                                   | direction
//   s_      | s_valid s_ready s_in_byte               | raw MIDI bytes in
//   m_      | m_valid m_ready m_out_byte              | framed message bytes out
//           | m_end_of_message                        |
//
// The parser takes one byte per cycle while the command queue has room.
// The engine writes each byte to the buffer, the running status first when it is
// reinserted; a finished message drains as a buffer read then an output register
// load per byte, and no new command is taken until it ends. Real-time bytes skip
// the buffer. Reset is synchronous and active low; rptr_reg and cmd_reg skip it.
// A stalled m_ready holds the drain; a full queue drops s_ready.
`timescale 1ns / 1ps

module midi_stream_message_framer #(
    parameter int MAX_MSG_BYTES = 64
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_end_of_message
);
    import msmf_pkg::*;

    msmf_cmd_t push_cmd;
    msmf_cmd_t head_cmd;
    logic      q_push;
    logic      q_full;
    logic      q_pop;
    logic      q_not_empty;

    msmf_front #(
        .MAX_MSG_BYTES(MAX_MSG_BYTES)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_in_byte (s_in_byte),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_cmd     (push_cmd)
    );

    msmf_cmd_fifo u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_cmd  (push_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_cmd  (head_cmd)
    );

    msmf_back #(
        .MAX_MSG_BYTES(MAX_MSG_BYTES)
    ) u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd_valid        (q_not_empty),
        .cmd              (head_cmd),
        .cmd_pop          (q_pop),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_out_byte       (m_out_byte),
        .m_end_of_message (m_end_of_message)
    );

endmodule

>>> bench/msmf_frame_checker.sv
`timescale 1ns / 1ps
// Frame checker for the MIDI stream message framer: mirrors the framing rules,
// queues the bytes each accepted request should produce and compares the m_ side.
// Depends on msmf_pkg for the status-byte constants.

module msmf_frame_checker #(
    parameter int MSG_CAP = 64
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_ready,
    input  logic [7:0] s_in_byte,
    input  logic       m_valid,
    input  logic       m_ready,
    input  logic [7:0] m_out_byte,
    input  logic       m_end_of_message,
    output int         mismatch_count,
    output int         pending_results
);

    import msmf_pkg::*;

    localparam int IW = $clog2(MSG_CAP);

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last;
    } frame_byte_t;

    frame_byte_t expected_frames[$];

    logic [7:0] held_bytes [MSG_CAP];
    int         held_cnt;
    int         msg_len;
    logic [7:0] running_st;
    logic       dump_open;
    int         errors = 0;

    function automatic int length_for(input logic [7:0] st);
        int len;
        len = 3;
        if (st >= SOX) begin
            len = 1;
            if (st == MTC_QF || st == SONG_SEL) begin
                len = 2;
            end else if (st == SONG_POS) begin
                len = 3;
            end
        end else if ((st & KIND_MASK) == PROG_CHG || (st & KIND_MASK) == CHAN_PRES) begin
            len = 2;
        end
        return len;
    endfunction

    task automatic queue_expected(input frame_byte_t fb);
        expected_frames.insert(expected_frames.size(), fb);
    endtask

    task automatic hold_byte(input logic [7:0] b);
        if (held_cnt < MSG_CAP) begin
            held_bytes[IW'(held_cnt)] = b;
            held_cnt++;
        end
    endtask

    task automatic emit_held();
        frame_byte_t fb;
        for (int i = 0; i < held_cnt; i++) begin
            fb.data_byte = held_bytes[IW'(i)];
            fb.last      = (i == held_cnt - 1);
            queue_expected(fb);
        end
        held_cnt = 0;
    endtask

    task automatic frame_midi_byte(input logic [7:0] b);
        frame_byte_t fb;
        if (b >= RT_MIN) begin
            // real-time passes straight through, message in progress untouched
            fb.data_byte = b;
            fb.last      = 1'b1;
            queue_expected(fb);
        end else if (b == EOX) begin
            if (dump_open) begin
                hold_byte(b);
                dump_open = 1'b0;
                emit_held();
            end
        end else if (b >= STATUS_MIN) begin
            // any other status drops the unfinished message
            held_cnt  = 0;
            dump_open = 1'b0;
            if (b == SOX) begin
                running_st = 8'h00;
                dump_open  = 1'b1;
                hold_byte(b);
            end else begin
                running_st = (b >= SOX) ? 8'h00 : b;
                msg_len    = length_for(b);
                hold_byte(b);
                if (held_cnt >= msg_len) begin
                    emit_held();
                end
            end
        end else if (dump_open) begin
            hold_byte(b);
            if (held_cnt >= MSG_CAP) begin
                emit_held();
            end
        end else if (held_cnt != 0 || running_st != 8'h00) begin
            if (held_cnt == 0) begin
                // put the running status back in front
                msg_len = length_for(running_st);
                hold_byte(running_st);
            end
            hold_byte(b);
            if (held_cnt >= msg_len) begin
                emit_held();
            end
        end
    endtask

    always @(posedge aclk) begin : watch
        frame_byte_t want;
        if (!aresetn) begin
            expected_frames.delete();
            held_cnt   = 0;
            msg_len    = 0;
            running_st = 8'h00;
            dump_open  = 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_frames.size() == 0) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("%0t: unexpected byte %02h eom %0d", $realtime,
                                 m_out_byte, m_end_of_message);
                    end
                end else begin
                    want = expected_frames.pop_front();
                    if (want.data_byte !== m_out_byte || want.last !== m_end_of_message) begin
                        errors++;
                        if (errors <= 10) begin
                            $display("%0t: byte expected %02h got %02h, eom expected %0d got %0d",
                                     $realtime, want.data_byte, m_out_byte, want.last,
                                     m_end_of_message);
                        end
                    end
                end
            end
            if (s_valid && s_ready) begin
                frame_midi_byte(s_in_byte);
            end
        end
        mismatch_count  <= errors;
        pending_results <= expected_frames.size();
    end

endmodule

>>> bench/tb_midi_stream_message_framer.sv
`timescale 1ns / 1ps
// Testbench top for the MIDI stream message framer: clock, reset, byte stimulus,
// receiver back-pressure and the verdict. Depends on msmf_pkg and msmf_frame_checker.

module tb_midi_stream_message_framer;

    import msmf_pkg::*;

    localparam int MSG_CAP     = 64;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_TAIL  = 200;
    localparam int TIMEOUT_NS  = 2_000_000;

    logic       aclk = 1'b0;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [7:0] s_in_byte;
    logic       m_valid;
    logic       m_ready;
    logic [7:0] m_out_byte;
    logic       m_end_of_message;

    int mismatch_count;
    int pending_results;
    int bytes_sent    = 0;
    int hold_requests = 0;
    int holds_done    = 0;
    bit steady        = 1'b0;
    bit rt_mix        = 1'b0;

    midi_stream_message_framer #(
        .MAX_MSG_BYTES(MSG_CAP)
    ) uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_in_byte       (s_in_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_byte      (m_out_byte),
        .m_end_of_message(m_end_of_message)
    );

    msmf_frame_checker #(
        .MSG_CAP(MSG_CAP)
    ) frame_chk (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_in_byte       (s_in_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_byte      (m_out_byte),
        .m_end_of_message(m_end_of_message),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("midi_stream_message_framer verification failed");
        $finish;
    end

    // Receiver: random idling, plus a long hold whenever one is requested.
    initial begin
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (hold_requests != holds_done) begin
                holds_done++;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                m_ready <= steady || ($urandom_range(99) >= 23);
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        while (!steady && $urandom_range(99) < 23) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_in_byte <= b;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        bytes_sent++;
    endtask

    // Sprinkle real-time bytes into the stream once the random part starts.
    task automatic send_wire(input logic [7:0] b);
        if (rt_mix && $urandom_range(99) < 6) begin
            send_byte(8'($urandom_range(RT_MIN, 8'hFF)));
        end
        send_byte(b);
    endtask

    task automatic send_voice();
        logic [7:0] st;
        int         n_data;
        int         groups;
        st     = 8'($urandom_range(STATUS_MIN, 8'hEF));
        n_data = ((st & KIND_MASK) == PROG_CHG || (st & KIND_MASK) == CHAN_PRES) ? 1 : 2;
        groups = $urandom_range(0, 3);
        send_wire(st);
        for (int g = 0; g <= groups; g++) begin
            for (int k = 0; k < n_data; k++) begin
                // cut the last message short now and then
                if (!(g == groups && k == n_data - 1 && $urandom_range(99) < 8)) begin
                    send_wire(8'($urandom_range(0, 127)));
                end
            end
        end
    endtask

    task automatic send_common();
        logic [7:0] st;
        int         n_data;
        st     = 8'($urandom_range(MTC_QF, 8'hF6));
        n_data = (st == SONG_POS) ? 2 : ((st == MTC_QF || st == SONG_SEL) ? 1 : 0);
        send_wire(st);
        repeat (n_data) send_wire(8'($urandom_range(0, 127)));
    endtask

    task automatic send_dump(input int n_data);
        send_wire(SOX);
        repeat (n_data) send_wire(8'($urandom_range(0, 127)));
        if ($urandom_range(99) < 85) begin
            send_wire(EOX);
        end else begin
            // abandon the dump with some other status
            send_wire(8'($urandom_range(STATUS_MIN, 8'hF6)));
        end
    endtask

    task automatic run_random(input int upto);
        int roll;
        while (bytes_sent < upto) begin
            roll = $urandom_range(99);
            if (roll < 40) begin
                send_voice();
            end else if (roll < 55) begin
                send_common();
            end else if (roll < 75) begin
                send_dump($urandom_range(0, 12));
            end else begin
                repeat ($urandom_range(1, 3)) send_wire(8'($urandom_range(0, 255)));
            end
        end
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_results != 0) begin
            @(posedge aclk);
        end
    endtask

    initial begin
        int base;
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_in_byte = 8'h00;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed opening
        send_byte(EOX);                     // stray end of exclusive, drop
        send_byte(RT_MIN);
        send_byte(8'h90);
        send_byte(8'h00);
        send_byte(8'h7F);
        send_byte(8'h40);                   // running status note on
        send_byte(8'h41);
        send_byte(PROG_CHG | 8'h03);
        send_byte(8'h7F);
        send_byte(8'h05);                   // running status program change
        send_byte(8'h80);
        send_byte(8'h3C);
        send_byte(8'hFF);                   // real-time in the middle of a message
        send_byte(8'h10);
        send_byte(8'hB0);
        send_byte(8'h07);
        send_byte(SONG_POS);                // abandons the control change
        send_byte(8'h01);
        send_byte(8'h02);
        send_byte(8'h55);                   // no running status left, drop
        send_byte(MTC_QF);
        send_byte(8'h12);
        send_byte(8'hF6);
        send_byte(SOX);
        send_byte(8'h7E);
        send_byte(8'hFE);
        send_byte(EOX);

        rt_mix = 1'b1;
        base   = bytes_sent;
        run_random(base + 8);

        steady = 1'b1;
        send_dump(MSG_CAP - 1 + $urandom_range(0, 6));   // long dump, chunk flush
        run_random(base + 80);
        steady = 1'b0;

        // hold the receiver while requests keep coming, then let it all drain
        hold_requests++;
        repeat (4) send_voice();
        wait_drained();

        run_random(base + 95);

        wait_drained();
        repeat (DRAIN_TAIL) @(posedge aclk);
        if (mismatch_count == 0 && pending_results == 0) begin
            $display("midi_stream_message_framer verification clean");
        end else begin
            $display("midi_stream_message_framer verification failed");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/msmf_pkg.sv
rtl/msmf_front.sv
rtl/msmf_cmd_fifo.sv
rtl/msmf_back.sv
rtl/midi_stream_message_framer.sv
bench/msmf_frame_checker.sv
bench/tb_midi_stream_message_framer.sv
